/* hw/rtl/frame_pacing_limiter_assert.svh */
// assertion macros for the frame pacing limiter checker
`ifndef FRAME_PACING_LIMITER_ASSERT_SVH
`define FRAME_PACING_LIMITER_ASSERT_SVH

// condition implies consequence in the same cycle
`define FPL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame pacing limiter check failed");

// condition implies consequence in the next cycle
`define FPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame pacing limiter check failed");

`endif

/* hw/rtl/fpl_pkg.sv */
// shared types, constants and helpers for the frame pacing limiter
package fpl_pkg;

    localparam int NOW_W      = 32;
    localparam int RATE_W     = 16;
    localparam int COUNT_W    = 6;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [9:0]         WAIT_CAP  = 10'd1001;
    localparam logic [COUNT_W-1:0] RATE_SPAN = 6'd60;
    localparam logic [RATE_W-1:0]  RATE_NUM  = 16'd60000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ENABLE        = 2'd0,
        CFG_PERIOD_ONE    = 2'd1,
        CFG_PERIOD_FIVE   = 2'd2,
        CFG_PERIOD_THIRTY = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_ONE,
        KIND_FIVE,
        KIND_THIRTY
    } kind_t;

    typedef struct packed {
        logic        enable;
        logic [9:0]  period_one;
        logic [12:0] period_five;
        logic [14:0] period_thirty;
    } cfg_t;

    // checkpoint picked by the frame count, which runs 1 to 60
    function automatic kind_t classify(input logic [COUNT_W-1:0] c);
        kind_t k;
        k = KIND_ONE;
        priority if (c == 6'd30 || c == 6'd60)
            k = KIND_THIRTY;
        else if (c == 6'd5 || c == 6'd10 || c == 6'd15 || c == 6'd20 || c == 6'd25 ||
                 c == 6'd35 || c == 6'd40 || c == 6'd45 || c == 6'd50 || c == 6'd55)
            k = KIND_FIVE;
        else
            k = KIND_ONE;
        return k;
    endfunction

endpackage

/* hw/rtl/fpl_alu.sv */
// shared add/subtract unit of the pacing sequencer
module fpl_alu #(
    parameter int WIDTH = 34
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] res
);

    assign res = sub ? (a - b) : (a + b);

endmodule

/* hw/rtl/fpl_core.sv */
// pacing sequencer: checkpoint math, rate division and output register
module fpl_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fpl_pkg::cfg_t                cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fpl_pkg::NOW_W-1:0]    in_now,
    input  logic                         in_skip,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fpl_pkg::NOW_W-1:0]    out_release,
    output logic                         out_rate_valid,
    output logic [fpl_pkg::RATE_W-1:0]   out_rate
);

    import fpl_pkg::*;

    localparam int ALU_W = TIME_WIDTH + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_CMP,
        ST_REL,
        ST_ELAP,
        ST_DIV,
        ST_ROUND,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [TIME_WIDTH-1:0]   now_reg, now_next;
    kind_t                   kind_reg, kind_next;
    logic                    rate_due_reg, rate_due_next;
    logic [TIME_WIDTH-1:0]   acc_reg, acc_next;
    logic [TIME_WIDTH-1:0]   rel_reg, rel_next;
    logic [TIME_WIDTH-1:0]   div_reg, div_next;
    logic [RATE_W-1:0]       rem_reg, rem_next;
    logic [RATE_W-1:0]       quo_reg, quo_next;
    logic [3:0]              bit_reg, bit_next;
    logic                    seeded_reg, seeded_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [TIME_WIDTH-1:0]   mark_one_reg, mark_one_next;
    logic [TIME_WIDTH-1:0]   mark_five_reg, mark_five_next;
    logic [TIME_WIDTH-1:0]   mark_thirty_reg, mark_thirty_next;
    logic [TIME_WIDTH-1:0]   mark_sixty_reg, mark_sixty_next;
    logic                    out_valid_reg, out_valid_next;
    logic [NOW_W-1:0]        out_rel_reg, out_rel_next;
    logic                    out_rate_valid_reg, out_rate_valid_next;
    logic [RATE_W-1:0]       out_rate_reg, out_rate_next;

    logic [ALU_W-1:0]        alu_a, alu_b, alu_res;
    logic                    alu_sub;
    logic [TIME_WIDTH-1:0]   now_in;
    logic [TIME_WIDTH-1:0]   mark_sel;
    logic [14:0]             period_sel;
    logic [RATE_W:0]         shifted;
    logic                    ge;
    logic                    no_wait;
    logic [COUNT_W-1:0]      count_plus;

    fpl_alu #(
        .WIDTH(ALU_W)
    ) u_alu (
        .a  (alu_a),
        .b  (alu_b),
        .sub(alu_sub),
        .res(alu_res)
    );

    assign now_in     = TIME_WIDTH'(in_now);
    assign count_plus = count_reg + COUNT_W'(1);
    assign shifted    = {rem_reg, RATE_NUM[bit_reg]};
    assign ge         = ~alu_res[ALU_W-1];
    assign no_wait    = alu_res[ALU_W-1] | (alu_res == '0);

    always_comb
    begin
        unique case (kind_reg)
            KIND_THIRTY:
            begin
                mark_sel   = mark_thirty_reg;
                period_sel = cfg.period_thirty;
            end
            KIND_FIVE:
            begin
                mark_sel   = mark_five_reg;
                period_sel = 15'(cfg.period_five);
            end
            default:
            begin
                mark_sel   = mark_one_reg;
                period_sel = 15'(cfg.period_one);
            end
        endcase
    end

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        unique case (state_reg)
            ST_DIFF:
            begin
                alu_a = ALU_W'(now_reg);
                alu_b = ALU_W'(mark_sel);
            end
            ST_CMP:
            begin
                alu_a = ALU_W'(period_sel);
                alu_b = ALU_W'(acc_reg);
            end
            ST_REL:
            begin
                alu_a   = ALU_W'(now_reg);
                alu_b   = ALU_W'(acc_reg);
                alu_sub = 1'b0;
            end
            ST_ELAP:
            begin
                alu_a = ALU_W'(rel_reg);
                alu_b = ALU_W'(mark_sixty_reg);
            end
            ST_DIV:
            begin
                alu_a = ALU_W'(shifted);
                alu_b = ALU_W'(div_reg);
            end
            ST_ROUND:
            begin
                alu_a = ALU_W'({rem_reg, 1'b0});
                alu_b = ALU_W'(div_reg);
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next          = state_reg;
        now_next            = now_reg;
        kind_next           = kind_reg;
        rate_due_next       = rate_due_reg;
        acc_next            = acc_reg;
        rel_next            = rel_reg;
        div_next            = div_reg;
        rem_next            = rem_reg;
        quo_next            = quo_reg;
        bit_next            = bit_reg;
        seeded_next         = seeded_reg;
        count_next          = count_reg;
        mark_one_next       = mark_one_reg;
        mark_five_next      = mark_five_reg;
        mark_thirty_next    = mark_thirty_reg;
        mark_sixty_next     = mark_sixty_reg;
        out_valid_next      = out_valid_reg & ~out_ready;
        out_rel_next        = out_rel_reg;
        out_rate_valid_next = out_rate_valid_reg;
        out_rate_next       = out_rate_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next = now_in;
                    if (!cfg.enable || in_skip)
                    begin
                        rel_next      = now_in;
                        rate_due_next = 1'b0;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        if (!seeded_reg)
                        begin
                            mark_one_next    = now_in;
                            mark_five_next   = now_in;
                            mark_thirty_next = now_in;
                            mark_sixty_next  = now_in;
                            seeded_next      = 1'b1;
                        end
                        kind_next     = classify(count_plus);
                        rate_due_next = (count_plus >= RATE_SPAN);
                        count_next    = (count_plus >= RATE_SPAN) ? '0 : count_plus;
                        state_next    = ST_DIFF;
                    end
                end
            end
            ST_DIFF:
            begin
                acc_next   = alu_res[TIME_WIDTH-1:0];
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (no_wait)
                    acc_next = '0;
                else if (alu_res > ALU_W'(WAIT_CAP))
                    acc_next = TIME_WIDTH'(WAIT_CAP);
                else
                    acc_next = alu_res[TIME_WIDTH-1:0];
                state_next = ST_REL;
            end
            ST_REL:
            begin
                rel_next      = alu_res[TIME_WIDTH-1:0];
                mark_one_next = alu_res[TIME_WIDTH-1:0];
                if (kind_reg == KIND_THIRTY)
                    mark_thirty_next = alu_res[TIME_WIDTH-1:0];
                if (kind_reg == KIND_FIVE)
                    mark_five_next = alu_res[TIME_WIDTH-1:0];
                state_next = rate_due_reg ? ST_ELAP : ST_DONE;
            end
            ST_ELAP:
            begin
                div_next = (alu_res[TIME_WIDTH-1:0] == '0) ? TIME_WIDTH'(1)
                                                           : alu_res[TIME_WIDTH-1:0];
                mark_sixty_next = rel_reg;
                rem_next        = '0;
                quo_next        = '0;
                bit_next        = 4'd15;
                state_next      = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = ge ? alu_res[RATE_W-1:0] : shifted[RATE_W-1:0];
                quo_next = {quo_reg[RATE_W-2:0], ge};
                bit_next = bit_reg - 4'd1;
                if (bit_reg == 4'd0)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (ge)
                    quo_next = quo_reg + RATE_W'(1);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    out_rel_next        = NOW_W'(rel_reg);
                    out_rate_valid_next = rate_due_reg;
                    out_rate_next       = rate_due_reg ? quo_reg : '0;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            seeded_reg      <= 1'b0;
            count_reg       <= '0;
            mark_one_reg    <= '0;
            mark_five_reg   <= '0;
            mark_thirty_reg <= '0;
            mark_sixty_reg  <= '0;
            out_valid_reg   <= 1'b0;
            kind_reg        <= KIND_ONE;
            rate_due_reg    <= 1'b0;
            bit_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            seeded_reg      <= seeded_next;
            count_reg       <= count_next;
            mark_one_reg    <= mark_one_next;
            mark_five_reg   <= mark_five_next;
            mark_thirty_reg <= mark_thirty_next;
            mark_sixty_reg  <= mark_sixty_next;
            out_valid_reg   <= out_valid_next;
            kind_reg        <= kind_next;
            rate_due_reg    <= rate_due_next;
            bit_reg         <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg            <= now_next;
        acc_reg            <= acc_next;
        rel_reg            <= rel_next;
        div_reg            <= div_next;
        rem_reg            <= rem_next;
        quo_reg            <= quo_next;
        out_rel_reg        <= out_rel_next;
        out_rate_valid_reg <= out_rate_valid_next;
        out_rate_reg       <= out_rate_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign out_release    = out_rel_reg;
    assign out_rate_valid = out_rate_valid_reg;
    assign out_rate       = out_rate_reg;

endmodule

/* hw/rtl/frame_pacing_limiter.sv */
// top level of the frame pacing limiter: config registers and stream ports
//
// Each frame-end word gives a release time; every 60th paced frame also reports
// the measured rate. All arithmetic runs through one shared add/subtract unit
// under a small sequencer, one word at a time. A bypassed word (pacing disabled
// or frame skipped) goes straight to the output step, a paced word passes
// through difference, compare and release add, and a word that reports the rate
// adds the elapsed-time subtract, a 16-step restoring division of 60000 by the
// elapsed time and a rounding step. The result sits in an output register, so a
// new word is taken while a finished one waits on m_tready; s_tready is low
// while the sequencer works. Configuration must be written only while no word
// is in flight; the block itself does not enforce this.
module frame_pacing_limiter #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fpl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [fpl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // now_ms
    input  logic [0:0]                        s_tuser,  // skip_frame
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,  // release_ms, measured_rate
    output logic [0:0]                        m_tuser   // rate_valid
);

    import fpl_pkg::*;

    cfg_t               cfg_reg;
    logic [NOW_W-1:0]   release_ms;
    logic               rate_valid;
    logic [RATE_W-1:0]  measured_rate;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= 1'b0;
            cfg_reg.period_one    <= 10'd16;
            cfg_reg.period_five   <= 13'd83;
            cfg_reg.period_thirty <= 15'd500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_ENABLE:        cfg_reg.enable        <= cfg_wdata[0];
                CFG_PERIOD_ONE:    cfg_reg.period_one    <= cfg_wdata[9:0];
                CFG_PERIOD_FIVE:   cfg_reg.period_five   <= cfg_wdata[12:0];
                CFG_PERIOD_THIRTY: cfg_reg.period_thirty <= cfg_wdata[14:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    fpl_core #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_now        (s_tdata),
        .in_skip       (s_tuser[0]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_release   (release_ms),
        .out_rate_valid(rate_valid),
        .out_rate      (measured_rate)
    );

    assign m_tdata = {measured_rate, release_ms};
    assign m_tuser = rate_valid;

endmodule

/* hw/rtl/fpl_checker.sv */
// port-level checks for the frame pacing limiter, bound to the top level
`include "frame_pacing_limiter_assert.svh"

module fpl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result word holds
    `FPL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // the sequencer is busy right after it takes a word
    `FPL_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // no rate report means a zero rate field
    `FPL_ASSERT_NOW(a_rate_zero, m_tvalid && !m_tuser[0], m_tdata[47:32] == 16'd0)

    // the rate stays at or below 60000
    `FPL_ASSERT_NOW(a_rate_range, m_tvalid && m_tuser[0], m_tdata[47:32] <= 16'd60000)

endmodule

bind frame_pacing_limiter fpl_checker u_fpl_checker (.*);

/* sim/frame_pacing_limiter_test.sv */
// self-checking stream testbench for the frame pacing limiter
`timescale 1ns / 1ps

module frame_pacing_limiter_test;

    import fpl_pkg::*;

    localparam int          TARGET_FRAMES = 1500;
    localparam int          TARGET_RATES  = 20;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          HOLD_CYCLES   = 500;
    localparam logic [31:0] MAX_WAIT_MS   = 32'd1001;
    localparam int          SPAN_FRAMES   = 60;

    typedef struct {
        logic [31:0] now_ms;
        logic        skip;
    } frame_t;

    typedef struct {
        logic [31:0] rel_ms;
        logic        rate_valid;
        logic [15:0] rate;
    } release_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;  // now_ms
    logic [0:0]            s_tuser = '0;  // skip_frame
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;       // release_ms, measured_rate
    logic [0:0]            m_tuser;       // rate_valid

    frame_pacing_limiter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // pacing state as the block should hold it
    logic        pace_enable = 1'b0;
    logic [9:0]  period_one = 10'd16;
    logic [12:0] period_five = 13'd83;
    logic [14:0] period_thirty = 15'd500;
    logic        seeded = 1'b0;
    int          frame_no = 0;
    logic [31:0] mark_one = '0;
    logic [31:0] mark_five = '0;
    logic [31:0] mark_thirty = '0;
    logic [31:0] mark_sixty = '0;

    frame_t      frame_q[$];
    release_t    pending_releases[$];
    frame_t      next_frame;
    release_t    want;

    int          fail_count = 0;
    int          frames_queued = 0;
    int          frames_paced = 0;
    int          rate_reports = 0;
    int          results_checked = 0;
    int          reg_writes = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] paced_release(logic [31:0] now_ms, logic [31:0] mark,
                                                  logic [14:0] period);
        logic [31:0] since;
        logic [31:0] hold_ms;
        since = now_ms - mark;
        if (since >= {17'd0, period})
            return now_ms;
        hold_ms = {17'd0, period} - since;
        if (hold_ms > MAX_WAIT_MS)
            hold_ms = MAX_WAIT_MS;
        return now_ms + hold_ms;
    endfunction

    function automatic logic [15:0] rate_of_span(logic [31:0] span);
        longint unsigned d;
        longint unsigned q;
        longint unsigned r;
        d = (span == 32'd0) ? 64'd1 : {32'd0, span};
        q = 64'd60000 / d;
        r = 64'd60000 % d;
        if (r >= d - r)
            q = q + 1;
        return q[15:0];
    endfunction

    function automatic void pace_frame(logic [31:0] now_ms, logic skip);
        release_t    res;
        logic [31:0] rel;
        res.rel_ms = now_ms;
        res.rate_valid = 1'b0;
        res.rate = '0;
        if (pace_enable && !skip)
        begin
            if (!seeded)
            begin
                mark_one = now_ms;
                mark_five = now_ms;
                mark_thirty = now_ms;
                mark_sixty = now_ms;
                seeded = 1'b1;
            end
            frame_no = frame_no + 1;
            frames_paced = frames_paced + 1;
            if (frame_no % 30 == 0)
            begin
                rel = paced_release(now_ms, mark_thirty, period_thirty);
                mark_thirty = rel;
            end
            else if (frame_no % 5 == 0)
            begin
                rel = paced_release(now_ms, mark_five, {2'd0, period_five});
                mark_five = rel;
            end
            else
                rel = paced_release(now_ms, mark_one, {5'd0, period_one});
            mark_one = rel;
            res.rel_ms = rel;
            if (frame_no >= SPAN_FRAMES)
            begin
                res.rate_valid = 1'b1;
                res.rate = rate_of_span(rel - mark_sixty);
                frame_no = 0;
                mark_sixty = rel;
                rate_reports = rate_reports + 1;
            end
        end
        pending_releases.push_back(res);
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            send_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (frame_q.size() != 0)
            begin
                next_frame = frame_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_frame.now_ms;
                s_tuser <= next_frame.skip;
                send_gap <= pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            automatic int unsigned g = pick_gap();
            if (g != 0)
            begin
                stall_left <= g - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // monitor: predict on input words, check output words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                pace_frame(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready)
            begin
                if (pending_releases.size() == 0)
                begin
                    $error("unexpected word: release_ms %0d", m_tdata[31:0]);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = pending_releases.pop_front();
                    results_checked = results_checked + 1;
                    if (m_tdata[31:0] !== want.rel_ms)
                    begin
                        $error("release_ms expected %0d actual %0d", want.rel_ms, m_tdata[31:0]);
                        fail_count = fail_count + 1;
                    end
                    if (m_tuser[0] !== want.rate_valid)
                    begin
                        $error("rate_valid expected %0d actual %0d", want.rate_valid, m_tuser[0]);
                        fail_count = fail_count + 1;
                    end
                    if (m_tdata[47:32] !== want.rate)
                    begin
                        $error("measured_rate expected %0d actual %0d", want.rate,
                               m_tdata[47:32]);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_ENABLE:        pace_enable = value[0];
            CFG_PERIOD_ONE:    period_one = value[9:0];
            CFG_PERIOD_FIVE:   period_five = value[12:0];
            CFG_PERIOD_THIRTY: period_thirty = value[14:0];
            default:           ;
        endcase
        reg_writes = reg_writes + 1;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_periods(int one, int five, int thirty);
        write_reg(CFG_PERIOD_ONE, CFG_DATA_W'(one));
        write_reg(CFG_PERIOD_FIVE, CFG_DATA_W'(five));
        write_reg(CFG_PERIOD_THIRTY, CFG_DATA_W'(thirty));
    endtask

    task automatic push_frame(logic [31:0] now_ms, logic skip);
        frame_t f;
        f.now_ms = now_ms;
        f.skip = skip;
        frame_q.push_back(f);
        frames_queued = frames_queued + 1;
    endtask

    task automatic wait_idle();
        while (frame_q.size() != 0 || s_tvalid || pending_releases.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int          phase;
        int          kind;
        int          n;
        int          k;
        int unsigned roll;
        logic [31:0] clock_ms;
        logic [31:0] step;
        logic [31:0] step_max;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bypass while disabled, field extremes
        push_frame(32'h0000_0000, 1'b0);
        push_frame(32'hFFFF_FFFF, 1'b1);
        push_frame(32'hFFFF_FFFF, 1'b0);
        push_frame(32'hAAAA_AAAA, 1'b0);
        push_frame(32'h5555_5555, 1'b1);
        wait_idle();

        // skipped frame before seeding, then seeding right below the wrap
        write_reg(CFG_ENABLE, CFG_DATA_W'(1));
        push_frame(32'd1000, 1'b1);
        push_frame(32'hFFFF_FFF0, 1'b0);
        push_frame(32'hFFFF_FFF4, 1'b0);
        push_frame(32'hFFFF_FFF8, 1'b0);
        push_frame(32'd2, 1'b0);
        push_frame(32'd3, 1'b0);
        wait_idle();

        // long periods, waits get capped
        write_periods(1000, 5000, 30000);
        push_frame(32'd10, 1'b0);
        push_frame(32'd11, 1'b0);
        push_frame(32'd12, 1'b1);
        push_frame(32'd13, 1'b0);
        push_frame(32'd14, 1'b0);
        push_frame(32'd15, 1'b0);
        wait_idle();

        clock_ms = 32'd20000;
        for (phase = 0;
             (frames_queued < TARGET_FRAMES || rate_reports < TARGET_RATES) && phase < 60;
             phase++)
        begin
            kind = phase % 9;
            quiet = ($urandom_range(0, 4) == 0);
            n = $urandom_range(100, 160);
            case (kind)
                1:
                begin
                    write_reg(CFG_ENABLE, CFG_DATA_W'(1));
                    write_periods(1000, 5000, 30000);
                end
                2, 3:
                begin
                    write_reg(CFG_ENABLE, CFG_DATA_W'(1));
                    write_periods(0, 0, 0);
                end
                4:
                begin
                    write_reg(CFG_ENABLE, CFG_DATA_W'({$urandom_range(0, 16383), 1'b1}));
                    write_periods($urandom_range(0, 32767), $urandom_range(0, 32767),
                                  $urandom_range(0, 32767));
                end
                5:
                begin
                    write_reg(CFG_ENABLE, CFG_DATA_W'({$urandom_range(0, 16383), 1'b0}));
                    write_periods($urandom_range(0, 1000), $urandom_range(0, 5000),
                                  $urandom_range(0, 30000));
                    n = 40;
                end
                6:
                begin
                    write_reg(CFG_ENABLE, CFG_DATA_W'(1));
                    write_periods($urandom_range(0, 1000), $urandom_range(0, 5000),
                                  $urandom_range(0, 30000));
                    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                end
                default:
                begin
                    write_reg(CFG_ENABLE, CFG_DATA_W'(1));
                    if ($urandom_range(0, 1) == 0)
                        write_periods($urandom_range(14, 40), $urandom_range(70, 200),
                                      $urandom_range(400, 1200));
                    else
                        write_periods($urandom_range(0, 1000), $urandom_range(0, 5000),
                                      $urandom_range(0, 30000));
                end
            endcase
            if (phase == 2)
                hold_req = 1'b1;
            step_max = period_one + period_one / 2 + 2;
            for (k = 0; k < n; k++)
            begin
                roll = $urandom_range(0, 99);
                if (kind == 2)
                    step = 32'd0;
                else if (kind == 3)
                    step = 32'd400;
                else if (roll < 2)
                    step = $urandom;
                else if (roll < 5)
                    step = $urandom_range(1000, 40000);
                else
                    step = $urandom_range(0, step_max);
                clock_ms = clock_ms + step;
                push_frame(clock_ms, (kind != 2 && kind != 3 && $urandom_range(0, 99) < 8));
            end
            wait_idle();
        end

        $display("checked %0d words from %0d frames, %0d of them paced, %0d rate reports",
                 results_checked, frames_queued, frames_paced, rate_reports);
        $display("%0d register writes over %0d setting phases, including extremes and wrap",
                 reg_writes, phase);
        if (fail_count == 0 && pending_releases.size() == 0)
            $display("frame_pacing_limiter_test passed");
        else
            $display("frame_pacing_limiter_test failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("frame_pacing_limiter_test failed");
        $finish;
    end

endmodule
